// ===== hdl/isut_pkg.sv =====
package isut_pkg;

   localparam int MAX_INTERVALS = 16;
   localparam int VALUE_BITS    = 32;
   localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
   localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] MEMB_NONE   = 2'd0;
   localparam logic [1:0] MEMB_INSIDE = 2'd1;
   localparam logic [1:0] MEMB_PART   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC,
      IDX_USED_M1
   } idx_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_SHIFT_UP,
      WR_NEW,
      WR_MERGE,
      WR_COMPACT
   } wr_op_type;

   typedef enum logic [1:0] {
      USED_HOLD,
      USED_CLEAR,
      USED_INC,
      USED_SUB
   } used_op_type;

   typedef struct packed {
      logic        load;
      idx_op_type  idx_op;
      wr_op_type   wr_op;
      logic        lo_set;
      logic        last_set;
      logic        delta_set;
      used_op_type used_op;
      logic        finish;
      logic [1:0]  membership;
      logic [1:0]  status;
   } dp_cmd_type;

   typedef struct packed {
      logic overflow;
      logic span_zero;
      logic idx_eq_used;
      logic idx_eq_lo;
      logic full;
      logic reach_lo;
      logic reach_hi;
      logic last_lt_s;
      logic e_lt_first;
      logic contained;
   } dp_stat_type;

endpackage

// ===== hdl/isut_datapath.sv =====
module isut_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [isut_pkg::VALUE_BITS-1:0]   req_start_req,
   input  logic [isut_pkg::VALUE_BITS-1:0]   req_span,
   input  isut_pkg::dp_cmd_type              cmd,
   output isut_pkg::dp_stat_type             stat,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_membership,
   output logic [1:0]                        rsp_status,
   output logic [isut_pkg::CNT_BITS-1:0]     rsp_entry_count
);
   import isut_pkg::*;

   logic [VALUE_BITS-1:0] first_mem [MAX_INTERVALS];
   logic [VALUE_BITS-1:0] last_mem  [MAX_INTERVALS];

   logic [VALUE_BITS-1:0] s_ff, e_ff, first_lo_ff, last_prev_ff;
   logic [VALUE_BITS-1:0] rd_first_ff, rd_last_ff;
   logic [CNT_BITS-1:0]   idx_ff, idx_in, lo_ff, delta_ff, used_ff, used_in;
   logic                  rsp_strobe_ff;
   logic [1:0]            rsp_membership_ff, rsp_status_ff;
   logic [CNT_BITS-1:0]   rsp_count_ff;

   logic [VALUE_BITS:0]   end_sum;
   logic [VALUE_BITS-1:0] merged_first, merged_last;
   logic [CNT_BITS-1:0]   up_addr, compact_addr;

   // inclusive end of the requested interval, carry marks passing the top
   assign end_sum = {1'b0, req_start_req} + {1'b0, req_span} - {{VALUE_BITS{1'b0}}, 1'b1};

   assign merged_first = (first_lo_ff < s_ff) ? first_lo_ff : s_ff;
   assign merged_last  = (last_prev_ff > e_ff) ? last_prev_ff : e_ff;
   assign up_addr      = idx_ff + {{(CNT_BITS-1){1'b0}}, 1'b1};
   assign compact_addr = idx_ff - delta_ff;

   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO:    idx_in = '0;
         IDX_INC:     idx_in = idx_ff + {{(CNT_BITS-1){1'b0}}, 1'b1};
         IDX_DEC:     idx_in = idx_ff - {{(CNT_BITS-1){1'b0}}, 1'b1};
         IDX_USED_M1: idx_in = used_ff - {{(CNT_BITS-1){1'b0}}, 1'b1};
         default:     idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.used_op)
         USED_CLEAR: used_in = '0;
         USED_INC:   used_in = used_ff + {{(CNT_BITS-1){1'b0}}, 1'b1};
         USED_SUB:   used_in = used_ff - delta_ff;
         default:    used_in = used_ff;
      endcase
   end

   always_comb begin
      stat.overflow    = end_sum[VALUE_BITS];
      stat.span_zero   = (req_span == '0);
      stat.idx_eq_used = (idx_ff == used_ff);
      stat.idx_eq_lo   = (idx_ff == lo_ff);
      stat.full        = (used_ff == CNT_BITS'(MAX_INTERVALS));
      // a value reaches an entry when it is no more than one past its end
      stat.reach_lo    = ({1'b0, s_ff} <= ({1'b0, rd_last_ff} + {{VALUE_BITS{1'b0}}, 1'b1}));
      stat.reach_hi    = ({1'b0, rd_first_ff} <= ({1'b0, e_ff} + {{VALUE_BITS{1'b0}}, 1'b1}));
      stat.last_lt_s   = (rd_last_ff < s_ff);
      stat.e_lt_first  = (e_ff < rd_first_ff);
      stat.contained   = (rd_first_ff <= s_ff) && (rd_last_ff >= e_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         lo_ff         <= '0;
         delta_ff      <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= cmd.finish;
         if (cmd.lo_set) begin
            lo_ff <= idx_ff;
         end
         if (cmd.delta_set) begin
            delta_ff <= idx_ff - lo_ff - {{(CNT_BITS-1){1'b0}}, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff <= req_start_req;
         e_ff <= end_sum[VALUE_BITS-1:0];
      end
      if (cmd.lo_set) begin
         first_lo_ff <= rd_first_ff;
      end
      if (cmd.last_set) begin
         last_prev_ff <= rd_last_ff;
      end
      if (cmd.finish) begin
         rsp_membership_ff <= cmd.membership;
         rsp_status_ff     <= cmd.status;
         rsp_count_ff      <= used_in;
      end
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      case (cmd.wr_op)
         WR_SHIFT_UP: begin
            first_mem[up_addr[IDX_BITS-1:0]] <= rd_first_ff;
            last_mem[up_addr[IDX_BITS-1:0]]  <= rd_last_ff;
         end
         WR_NEW: begin
            first_mem[lo_ff[IDX_BITS-1:0]] <= s_ff;
            last_mem[lo_ff[IDX_BITS-1:0]]  <= e_ff;
         end
         WR_MERGE: begin
            first_mem[lo_ff[IDX_BITS-1:0]] <= merged_first;
            last_mem[lo_ff[IDX_BITS-1:0]]  <= merged_last;
         end
         WR_COMPACT: begin
            first_mem[compact_addr[IDX_BITS-1:0]] <= rd_first_ff;
            last_mem[compact_addr[IDX_BITS-1:0]]  <= rd_last_ff;
         end
         default: begin
         end
      endcase
      rd_first_ff <= first_mem[idx_in[IDX_BITS-1:0]];
      rd_last_ff  <= last_mem[idx_in[IDX_BITS-1:0]];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_membership  = rsp_membership_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== hdl/isut_ctrl.sv =====
module isut_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_action,
   input  isut_pkg::dp_stat_type stat,
   output isut_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import isut_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_LO,
      ST_INS_HI,
      ST_INS_NEW,
      ST_INS_SHIFT,
      ST_INS_PLACE,
      ST_INS_MERGE,
      ST_INS_COMPACT,
      ST_QRY_SCAN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.load       = 1'b0;
      cmd.idx_op     = IDX_HOLD;
      cmd.wr_op      = WR_NONE;
      cmd.lo_set     = 1'b0;
      cmd.last_set   = 1'b0;
      cmd.delta_set  = 1'b0;
      cmd.used_op    = USED_HOLD;
      cmd.finish     = 1'b0;
      cmd.membership = MEMB_NONE;
      cmd.status     = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action) inside
                  ACT_CLEAR: begin
                     cmd.used_op = USED_CLEAR;
                     cmd.finish  = 1'b1;
                  end
                  ACT_INSERT, ACT_QUERY: begin
                     if (stat.span_zero) begin
                        cmd.finish = 1'b1;
                     end else if (stat.overflow) begin
                        cmd.finish = 1'b1;
                        cmd.status = STAT_RANGE;
                     end else begin
                        cmd.load   = 1'b1;
                        cmd.idx_op = IDX_ZERO;
                        state_in   = (req_action == ACT_INSERT) ? ST_INS_LO : ST_QRY_SCAN;
                     end
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         // find the first entry the new interval can touch
         ST_INS_LO: begin
            if (stat.idx_eq_used) begin
               cmd.lo_set = 1'b1;
               state_in   = ST_INS_NEW;
            end else if (stat.reach_lo) begin
               cmd.lo_set = 1'b1;
               state_in   = ST_INS_HI;
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end
         // walk over every entry the interval overlaps or adjoins
         ST_INS_HI: begin
            if (stat.idx_eq_used || !stat.reach_hi) begin
               cmd.delta_set = 1'b1;
               state_in      = stat.idx_eq_lo ? ST_INS_NEW : ST_INS_MERGE;
            end else begin
               cmd.last_set = 1'b1;
               cmd.idx_op   = IDX_INC;
            end
         end
         ST_INS_NEW: begin
            if (stat.full) begin
               cmd.finish = 1'b1;
               cmd.status = STAT_FULL;
               state_in   = ST_IDLE;
            end else if (stat.idx_eq_used) begin
               cmd.wr_op   = WR_NEW;
               cmd.used_op = USED_INC;
               cmd.finish  = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.idx_op = IDX_USED_M1;
               state_in   = ST_INS_SHIFT;
            end
         end
         // open a slot at lo, moving the tail up from the top
         ST_INS_SHIFT: begin
            cmd.wr_op = WR_SHIFT_UP;
            if (stat.idx_eq_lo) begin
               state_in = ST_INS_PLACE;
            end else begin
               cmd.idx_op = IDX_DEC;
            end
         end
         ST_INS_PLACE: begin
            cmd.wr_op   = WR_NEW;
            cmd.used_op = USED_INC;
            cmd.finish  = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_INS_MERGE: begin
            cmd.wr_op = WR_MERGE;
            state_in  = ST_INS_COMPACT;
         end
         // close the gap left by the collapsed entries
         ST_INS_COMPACT: begin
            if (stat.idx_eq_used) begin
               cmd.used_op = USED_SUB;
               cmd.finish  = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.wr_op  = WR_COMPACT;
               cmd.idx_op = IDX_INC;
            end
         end
         ST_QRY_SCAN: begin
            if (stat.idx_eq_used) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (stat.last_lt_s) begin
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
               if (stat.e_lt_first) begin
                  cmd.membership = MEMB_NONE;
               end else if (stat.contained) begin
                  cmd.membership = MEMB_INSIDE;
               end else begin
                  cmd.membership = MEMB_PART;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/interval_set_union_table.sv =====
// interval set union table: a sorted set of up to MAX_INTERVALS disjoint,
// non-adjacent intervals of unsigned values.
// request channel: a word (req_action, req_start_req, req_span) is taken at
// a rising edge with start high and busy low. actions: insert unites the
// interval with the set, query reports no overlap, containment in one entry
// or partial overlap, clear empties the set.
// response channel: rsp_strobe is high for exactly one cycle per request,
// with rsp_membership, rsp_status and rsp_entry_count valid in that cycle.
// the receiver cannot stall; each response is taken when it is shown.
// latency: clear, empty and out-of-range requests answer in the cycle after
// start. a query walks the entry memory one entry per cycle. an insert
// walks the entries it passes, then moves the tail one entry per cycle to
// open or close slots. the walk over the entry memory sets the response
// time; busy stays high until the response is issued, and the next
// request may be taken in the cycle the response is shown.
// reset empties the set and leaves no response pending.
module interval_set_union_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_action,
   input  logic [isut_pkg::VALUE_BITS-1:0]  req_start_req,
   input  logic [isut_pkg::VALUE_BITS-1:0]  req_span,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_membership,
   output logic [1:0]                       rsp_status,
   output logic [isut_pkg::CNT_BITS-1:0]    rsp_entry_count
);
   import isut_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   isut_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   isut_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_start_req   (req_start_req),
      .req_span        (req_span),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_membership  (rsp_membership),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_entry_count <= CNT_BITS'(MAX_INTERVALS)))
      else $error("entry count beyond capacity");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_FULL) |->
         (rsp_entry_count == CNT_BITS'(MAX_INTERVALS) && rsp_membership == MEMB_NONE))
      else $error("insert dropped while table not full");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy && req_action == ACT_CLEAR) |=>
         (rsp_strobe && rsp_entry_count == '0 && rsp_status == STAT_OK))
      else $error("clear did not empty the set");

   a_range_member: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STAT_RANGE) |-> (rsp_membership == MEMB_NONE))
      else $error("membership reported for out-of-range request");

endmodule
